[design/bc13_pkg.sv]
// Shared types, constants and arithmetic helpers for the BC1/BC3 texel decoder.
package bc13_pkg;

   // Selector codes of the color palette
   localparam logic [1:0] SEL_E0   = 2'd0;
   localparam logic [1:0] SEL_E1   = 2'd1;
   localparam logic [1:0] SEL_MIX0 = 2'd2;
   localparam logic [1:0] SEL_MIX1 = 2'd3;

   // Alpha index codes with fixed meaning
   localparam logic [2:0] AIDX_A0   = 3'd0;
   localparam logic [2:0] AIDX_A1   = 3'd1;
   localparam logic [2:0] AIDX_ZERO = 3'd6;
   localparam logic [2:0] AIDX_FULL = 3'd7;

   // Final scaling applied to a color numerator
   typedef logic [1:0] color_op_type;
   localparam color_op_type COP_PASS  = 2'd0;
   localparam color_op_type COP_HALF  = 2'd1;
   localparam color_op_type COP_THIRD = 2'd2;

   // Final scaling applied to an alpha numerator
   typedef logic [1:0] alpha_op_type;
   localparam alpha_op_type AOP_PASS    = 2'd0;
   localparam alpha_op_type AOP_FIFTH   = 2'd1;
   localparam alpha_op_type AOP_SEVENTH = 2'd2;

   // Request payload
   typedef struct packed {
      logic [63:0] color_word;
      logic [63:0] alpha_word;
      logic [1:0]  texel_column;
      logic [1:0]  texel_row;
   } req_type;

   // Palette stage output: numerators plus the divide still to be done
   typedef struct packed {
      logic [9:0]   num_red;
      logic [9:0]   num_green;
      logic [9:0]   num_blue;
      color_op_type color_op;
      logic [10:0]  num_alpha;
      alpha_op_type alpha_op;
   } stage_type;

   // Result payload
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rsp_type;

   // Endpoint expansion tables: x * 255 / max, truncated
   typedef logic [31:0][7:0] exp5_type;
   typedef logic [63:0][7:0] exp6_type;

   function automatic exp5_type build_exp5();
      exp5_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'((i * 255) / 31);
      end
      return t;
   endfunction

   function automatic exp6_type build_exp6();
      exp6_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * 255) / 63);
      end
      return t;
   endfunction

   localparam exp5_type EXPAND5 = build_exp5();
   localparam exp6_type EXPAND6 = build_exp6();

   // n / 3 for n < 768: reciprocal 683 / 2^11
   function automatic logic [7:0] div3(input logic [9:0] n);
      logic [20:0] prod;
      prod = {11'b0, n} * 21'd683;
      return prod[18:11];
   endfunction

   // n / 5 for n < 1280: reciprocal 1639 / 2^13
   function automatic logic [7:0] div5(input logic [10:0] n);
      logic [21:0] prod;
      prod = {11'b0, n} * 22'd1639;
      return prod[20:13];
   endfunction

   // n / 7 for n < 1792: reciprocal 2341 / 2^14
   function automatic logic [7:0] div7(input logic [10:0] n);
      logic [22:0] prod;
      prod = {12'b0, n} * 23'd2341;
      return prod[21:14];
   endfunction

endpackage

[design/bc13_if.sv]
// Valid/ready channel interfaces for request, response and register write.
interface bc13_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] color_word;
   logic [63:0] alpha_word;
   logic [1:0]  texel_column;
   logic [1:0]  texel_row;

   modport source(output valid, color_word, alpha_word, texel_column, texel_row,
                  input ready);
   modport sink(input valid, color_word, alpha_word, texel_column, texel_row,
                output ready);
endinterface

interface bc13_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;

   modport source(output valid, red, green, blue, alpha, input ready);
   modport sink(input valid, red, green, blue, alpha, output ready);
endinterface

interface bc13_csr_if;
   logic valid;
   logic ready;
   logic bc3_mode;

   modport source(output valid, bc3_mode, input ready);
   modport sink(input valid, bc3_mode, output ready);
endinterface

[design/bc13_palette.sv]
// Palette stage: texel selection, endpoint expansion and palette numerators.
module bc13_palette (
   input  bc13_pkg::req_type   req,
   input  logic                bc3_mode,
   output bc13_pkg::stage_type stage
);

   logic [3:0]  texel_num;
   logic [31:0] selectors;
   logic [47:0] alpha_indices;
   logic [5:0]  alpha_ofs;
   logic [1:0]  sel;
   logic [2:0]  aidx;
   logic [15:0] c0;
   logic [15:0] c1;
   logic        four;
   logic [7:0]  e0_red, e0_green, e0_blue;
   logic [7:0]  e1_red, e1_green, e1_blue;
   logic [7:0]  a0;
   logic [7:0]  a1;
   logic [2:0]  wt1;
   logic [2:0]  wt0;

   // Numerator of one color channel for the chosen palette entry
   function automatic logic [9:0] chan_num(input logic [7:0] e0, input logic [7:0] e1,
                                           input logic [1:0] s, input logic four_mode);
      logic [9:0] n;
      case (s)
         bc13_pkg::SEL_E0: n = {2'b0, e0};
         bc13_pkg::SEL_E1: n = {2'b0, e1};
         bc13_pkg::SEL_MIX0: begin
            if (four_mode) n = {1'b0, e0, 1'b0} + {2'b0, e1};
            else           n = {2'b0, e0} + {2'b0, e1};
         end
         default: begin
            if (four_mode) n = {2'b0, e0} + {1'b0, e1, 1'b0};
            else           n = '0;
         end
      endcase
      return n;
   endfunction

   // Pick the texel's selector and alpha index
   assign texel_num     = {req.texel_row, req.texel_column};
   assign selectors     = req.color_word[63:32];
   assign alpha_indices = req.alpha_word[63:16];
   assign alpha_ofs     = {2'b0, texel_num} + {1'b0, texel_num, 1'b0};
   assign sel           = selectors[{texel_num, 1'b0} +: 2];
   assign aidx          = alpha_indices[alpha_ofs +: 3];

   // Endpoints and palette mode
   assign c0   = req.color_word[15:0];
   assign c1   = req.color_word[31:16];
   assign four = (c0 > c1) || bc3_mode;

   assign e0_red   = bc13_pkg::EXPAND5[c0[15:11]];
   assign e0_green = bc13_pkg::EXPAND6[c0[10:5]];
   assign e0_blue  = bc13_pkg::EXPAND5[c0[4:0]];
   assign e1_red   = bc13_pkg::EXPAND5[c1[15:11]];
   assign e1_green = bc13_pkg::EXPAND6[c1[10:5]];
   assign e1_blue  = bc13_pkg::EXPAND5[c1[4:0]];

   assign a0  = req.alpha_word[7:0];
   assign a1  = req.alpha_word[15:8];
   assign wt1 = aidx - 3'd1;
   assign wt0 = (a0 > a1) ? (3'd7 - wt1) : (3'd5 - wt1);

   // Color and alpha numerators with the divide still to be done
   always_comb begin
      stage.num_red   = chan_num(e0_red, e1_red, sel, four);
      stage.num_green = chan_num(e0_green, e1_green, sel, four);
      stage.num_blue  = chan_num(e0_blue, e1_blue, sel, four);
      if (sel == bc13_pkg::SEL_E0 || sel == bc13_pkg::SEL_E1) begin
         stage.color_op = bc13_pkg::COP_PASS;
      end else if (four) begin
         stage.color_op = bc13_pkg::COP_THIRD;
      end else if (sel == bc13_pkg::SEL_MIX0) begin
         stage.color_op = bc13_pkg::COP_HALF;
      end else begin
         stage.color_op = bc13_pkg::COP_PASS;
      end

      // Alpha numerator and its divide
      stage.alpha_op = bc13_pkg::AOP_PASS;
      if (!bc3_mode) begin
         // BC1: only transparent black carries zero alpha
         stage.num_alpha = (!four && sel == bc13_pkg::SEL_MIX1) ? 11'd0 : 11'd255;
      end else if (aidx == bc13_pkg::AIDX_A0) begin
         stage.num_alpha = {3'b0, a0};
      end else if (aidx == bc13_pkg::AIDX_A1) begin
         stage.num_alpha = {3'b0, a1};
      end else if (a0 > a1) begin
         stage.num_alpha = ({8'b0, wt0} * {3'b0, a0}) + ({8'b0, wt1} * {3'b0, a1});
         stage.alpha_op  = bc13_pkg::AOP_SEVENTH;
      end else if (aidx == bc13_pkg::AIDX_ZERO) begin
         stage.num_alpha = 11'd0;
      end else if (aidx == bc13_pkg::AIDX_FULL) begin
         stage.num_alpha = 11'd255;
      end else begin
         stage.num_alpha = ({8'b0, wt0} * {3'b0, a0}) + ({8'b0, wt1} * {3'b0, a1});
         stage.alpha_op  = bc13_pkg::AOP_FIFTH;
      end
   end

endmodule

[design/bc1_bc3_texel_decoder.sv]
// Top level of the BC1/BC3 single-texel decoder.
// A request passes through the input register, the palette register and the output register, in that order.
// Throughput: one texel per cycle; the pipeline stalls only when the result is not taken.
// Reset clears all stage valid flags and selects BC1 mode.
module bc1_bc3_texel_decoder (
   input logic        clock,
   input logic        reset,
   bc13_req_if.sink   req_chan,
   bc13_rsp_if.source rsp_chan,
   bc13_csr_if.sink   csr_chan
);

   logic                bc3_mode_ff;
   logic                bc3_mode_in;
   logic                s1_valid_ff, s1_valid_in;
   bc13_pkg::req_type   s1_req_ff;
   bc13_pkg::req_type   s1_req_in;
   logic                s2_valid_ff, s2_valid_in;
   bc13_pkg::stage_type s2_ff;
   bc13_pkg::stage_type s2_in;
   logic                out_valid_ff, out_valid_in;
   bc13_pkg::rsp_type   out_ff;
   bc13_pkg::rsp_type   out_in;
   logic                out_en, s2_en, s1_en;

   // Mode register; the user writes it only while idle, the block itself does not enforce this
   assign csr_chan.ready = 1'b1;
   assign bc3_mode_in    = (csr_chan.valid) ? csr_chan.bc3_mode : bc3_mode_ff;

   // Stall chain from the response side back to the request side
   assign out_en         = !out_valid_ff || rsp_chan.ready;
   assign s2_en          = !s2_valid_ff || out_en;
   assign s1_en          = !s1_valid_ff || s2_en;
   assign req_chan.ready = s1_en;

   // Input register
   assign s1_valid_in = s1_en ? req_chan.valid : s1_valid_ff;
   always_comb begin
      s1_req_in.color_word   = req_chan.color_word;
      s1_req_in.alpha_word   = req_chan.alpha_word;
      s1_req_in.texel_column = req_chan.texel_column;
      s1_req_in.texel_row    = req_chan.texel_row;
   end

   // Palette numerators
   bc13_palette u_palette (
      .req      (s1_req_ff),
      .bc3_mode (bc3_mode_ff),
      .stage    (s2_in)
   );
   assign s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;

   // Constant divides into the result register
   function automatic logic [7:0] color_div(input logic [9:0] n,
                                            input bc13_pkg::color_op_type op);
      logic [7:0] r;
      case (op)
         bc13_pkg::COP_HALF:  r = n[8:1];
         bc13_pkg::COP_THIRD: r = bc13_pkg::div3(n);
         default:             r = n[7:0];
      endcase
      return r;
   endfunction

   always_comb begin
      out_in.red   = color_div(s2_ff.num_red, s2_ff.color_op);
      out_in.green = color_div(s2_ff.num_green, s2_ff.color_op);
      out_in.blue  = color_div(s2_ff.num_blue, s2_ff.color_op);
      case (s2_ff.alpha_op)
         bc13_pkg::AOP_FIFTH:   out_in.alpha = bc13_pkg::div5(s2_ff.num_alpha);
         bc13_pkg::AOP_SEVENTH: out_in.alpha = bc13_pkg::div7(s2_ff.num_alpha);
         default:               out_in.alpha = s2_ff.num_alpha[7:0];
      endcase
   end
   assign out_valid_in = out_en ? s2_valid_ff : (out_valid_ff && !rsp_chan.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bc3_mode_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bc3_mode_ff  <= bc3_mode_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_en) s1_req_ff <= s1_req_in;
      if (s2_en) s2_ff     <= s2_in;
      if (out_en) out_ff   <= out_in;
   end

   // Response port
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.red   = out_ff.red;
   assign rsp_chan.green = out_ff.green;
   assign rsp_chan.blue  = out_ff.blue;
   assign rsp_chan.alpha = out_ff.alpha;

endmodule

[design/bc13_checker.sv]
// Port-level assertions for the texel decoder, bound to the top level.
module bc13_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] red,
   input logic [7:0] green,
   input logic [7:0] blue,
   input logic [7:0] alpha
);

   // No result is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An accepted request reaches the output when the output keeps draining
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("request did not produce a response in time");

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(red) && $stable(green) && $stable(blue) && $stable(alpha)))
      else $error("response payload changed while stalled");

endmodule

bind bc1_bc3_texel_decoder bc13_checker u_bc13_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .red       (rsp_chan.red),
   .green     (rsp_chan.green),
   .blue      (rsp_chan.blue),
   .alpha     (rsp_chan.alpha)
);
